// ----- rtl/core/trds_pkg.sv -----
`timescale 1ns / 1ps
package trds_pkg;

  typedef enum logic [1:0] {
    OP_PIC_PIXEL = 2'd0,
    OP_OBJ_PIXEL = 2'd1,
    OP_OBJ_HEADER = 2'd2,
    OP_RUN = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CFG_PICTURE_DIM = 2'd0,
    CFG_OBJECT_COUNT = 2'd1,
    CFG_MATCH_THRESHOLD = 2'd2
  } cfg_reg_t;

  localparam logic [23:0] TERM_SAT = 24'hFFFFFF;
  localparam logic KIND_FOUND = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_OBJ,
    S_LIM,
    S_RD,
    S_LD,
    S_DIV,
    S_ACC,
    S_CMP,
    S_NEXT,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [2:0]  slot;
    logic [11:0] address;
    logic [7:0]  pixel;
    logic [9:0]  header_id;
    logic [5:0]  header_dim;
  } in_word_t;

  typedef struct packed {
    logic        kind;
    logic [9:0]  found_id;
    logic [5:0]  found_row;
    logic [5:0]  found_col;
    logic [1:0]  found_count;
    logic        three_found;
    logic        last;
  } out_word_t;

endpackage

// ----- rtl/core/template_relative_diff_search.sv -----
`timescale 1ns / 1ps
// Template search by mean relative difference.
// Input channel (in_valid/in_stall/in_data): load words write a picture pixel,
// an object pixel or an object header, and loads stream at one word per cycle
// while idle. A run word holds in_stall high until the run is over. The user
// writes configuration (cfg_valid/cfg_ready, always ready) only while idle;
// the block does not enforce it. A run walks the objects in slot order and each
// window position row-major. Each pixel of a window takes a memory read, an
// operand latch, a PIXEL_BITS+16 step restoring divider for the relative
// difference, and an accumulate; a zero picture pixel skips the divider.
// Each window ends with a compare, and an object wider than the picture is
// skipped without a search. The run then emits one word per recorded match
// and a final status word, one per cycle while out_stall is low; the output
// register holds a word while the receiver stalls and the emitter waits.
// Reset initialises state, configuration, headers and found list; datapath
// registers and pixel memories are not cleared and hold whatever was last written.
module template_relative_diff_search
  import trds_pkg::*;
#(
  parameter int PIC_DIM_MAX = 64,
  parameter int OBJ_DIM_MAX = 32,
  parameter int OBJ_SLOTS = 8,
  parameter int FOUND_NEEDED = 3,
  parameter int PIXEL_BITS = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  localparam int PIC_CELLS = PIC_DIM_MAX * PIC_DIM_MAX;
  localparam int PAW = $clog2(PIC_CELLS);
  localparam int OBJ_CELLS = OBJ_DIM_MAX * OBJ_DIM_MAX;
  localparam int OMD = OBJ_SLOTS * OBJ_CELLS;
  localparam int OAW = (OMD > 1) ? $clog2(OMD) : 1;
  localparam int NW = $clog2(OBJ_CELLS + 1);
  localparam int ODW = $clog2(OBJ_DIM_MAX + 1);
  localparam int PDW = $clog2(PIC_DIM_MAX + 1);
  localparam int PIW = $clog2(PIC_DIM_MAX);
  localparam int SW = $clog2(OBJ_SLOTS + 1);
  localparam int SIW = (OBJ_SLOTS > 1) ? $clog2(OBJ_SLOTS) : 1;
  localparam int FW = $clog2(FOUND_NEEDED + 1);
  localparam int FIW = (FOUND_NEEDED > 1) ? $clog2(FOUND_NEEDED) : 1;
  localparam int QW = PIXEL_BITS + 16;
  localparam int DCW = $clog2(QW);
  localparam int SUMW = 24 + NW;

  state_t state_r, state_nxt;

  logic [6:0]  pdim_r;
  logic [3:0]  ocnt_r;
  logic [23:0] thr_r;

  logic [9:0]     ids_r [OBJ_SLOTS];
  logic [ODW-1:0] dims_r [OBJ_SLOTS];
  logic [9:0]     fids_r [FOUND_NEEDED];
  logic [PIW-1:0] frow_r [FOUND_NEEDED];
  logic [PIW-1:0] fcol_r [FOUND_NEEDED];
  logic [FW-1:0]  total_r, total_nxt;

  logic [PDW-1:0]  pd_r, pd_nxt;
  logic [SW-1:0]   cnt_r, cnt_nxt, s_r, s_nxt;
  logic [ODW-1:0]  od_r, od_nxt, i_r, i_nxt, j_r, j_nxt;
  logic [NW-1:0]   n_r, n_nxt, k_r, k_nxt;
  logic [SUMW-1:0] lim_r, lim_nxt, sum_r, sum_nxt;
  logic [PIW-1:0]  r_r, r_nxt, c_r, c_nxt;
  logic [PAW-1:0]  wbase_r, wbase_nxt, raddr_r, raddr_nxt;
  logic [PIXEL_BITS-1:0] rem_r, rem_nxt;
  logic [QW-1:0]   quo_r, quo_nxt;
  logic [DCW-1:0]  dcnt_r, dcnt_nxt;
  logic            zero_r, zero_nxt;
  logic [FW-1:0]   e_r, e_nxt;
  logic            out_valid_r;
  out_word_t       out_data_r;

  logic [PIXEL_BITS-1:0] pic_mem [PIC_CELLS];
  logic [PIXEL_BITS-1:0] obj_mem [OMD];
  logic [PIXEL_BITS-1:0] pic_q, obj_q;
  logic [OAW-1:0] obj_ra;
  logic rd_en;

  logic in_acc, run_go, rec, out_free, distinct;
  logic [PIXEL_BITS-1:0] wpix, diff;
  logic [PIXEL_BITS:0]   tmp;
  logic [PIXEL_BITS+1:0] dif;
  logic [23:0] term;
  logic [9:0]  cur_id;
  logic [ODW-1:0] hdim_sat;

  assign in_acc = in_valid && !in_stall;
  assign run_go = in_acc && (in_data.operation == OP_RUN);
  assign out_free = !out_valid_r || !out_stall;
  assign wpix = PIXEL_BITS'(in_data.pixel);
  assign cur_id = ids_r[SIW'(s_r)];
  assign obj_ra = OAW'(int'(s_r) * OBJ_CELLS + int'(k_r));
  assign tmp = {rem_r, quo_r[QW-1]};
  assign dif = {1'b0, tmp} - {2'b00, pic_q};
  assign diff = (pic_q > obj_q) ? pic_q - obj_q : obj_q - pic_q;
  assign term = zero_r ? TERM_SAT : ((quo_r > QW'(TERM_SAT)) ? TERM_SAT : 24'(quo_r));
  assign rec = (sum_r <= lim_r) &&
               ((total_r == '0) || (fids_r[FIW'(total_r - 1'b1)] != cur_id));

  always_comb begin
    if (int'(in_data.header_dim) < 1) begin
      hdim_sat = ODW'(1);
    end else if (int'(in_data.header_dim) > OBJ_DIM_MAX) begin
      hdim_sat = ODW'(OBJ_DIM_MAX);
    end else begin
      hdim_sat = ODW'(in_data.header_dim);
    end
  end

  always_comb begin
    distinct = 1'b1;
    for (int a = 0; a < FOUND_NEEDED; a++) begin
      for (int b = a + 1; b < FOUND_NEEDED; b++) begin
        if (fids_r[a] == fids_r[b]) begin
          distinct = 1'b0;
        end
      end
    end
  end

  // Pixel memories.
  always_ff @(posedge clk) begin
    if (in_acc && (in_data.operation == OP_PIC_PIXEL) && (int'(in_data.address) < PIC_CELLS))
    begin
      pic_mem[PAW'(in_data.address)] <= wpix;
    end
    if (rd_en) begin
      pic_q <= pic_mem[raddr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && (in_data.operation == OP_OBJ_PIXEL) && (int'(in_data.slot) < OBJ_SLOTS) &&
        (int'(in_data.address) < OBJ_CELLS)) begin
      obj_mem[OAW'(int'(in_data.slot) * OBJ_CELLS + int'(in_data.address))] <= wpix;
    end
    if (rd_en) begin
      obj_q <= obj_mem[obj_ra];
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (run_go) state_nxt = S_OBJ;
      S_OBJ: begin
        if (s_r >= cnt_r) begin
          state_nxt = S_EMIT;
        end else if (int'(dims_r[SIW'(s_r)]) > int'(pd_r)) begin
          state_nxt = S_NEXT;
        end else begin
          state_nxt = S_LIM;
        end
      end
      S_LIM: state_nxt = S_RD;
      S_RD: state_nxt = S_LD;
      S_LD: state_nxt = (pic_q == '0) ? S_ACC : S_DIV;
      S_DIV: if (dcnt_r == DCW'(QW - 1)) state_nxt = S_ACC;
      S_ACC: begin
        if ((j_r == od_r - 1'b1) && (i_r == od_r - 1'b1)) begin
          state_nxt = S_CMP;
        end else begin
          state_nxt = S_RD;
        end
      end
      S_CMP: begin
        if (sum_r <= lim_r) begin
          state_nxt = S_NEXT;
        end else if (int'(c_r) + int'(od_r) < int'(pd_r) ||
                     int'(r_r) + int'(od_r) < int'(pd_r)) begin
          state_nxt = S_RD;
        end else begin
          state_nxt = S_NEXT;
        end
      end
      S_NEXT: begin
        if (int'(total_r) >= FOUND_NEEDED ||
            int'(cnt_r) - int'(s_r) - 1 < FOUND_NEEDED - int'(total_r)) begin
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_OBJ;
        end
      end
      S_EMIT: if (out_free && (e_r == total_r)) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_stall = (state_r != S_IDLE);
    rd_en = (state_r == S_RD);
  end

  // Datapath next values.
  always_comb begin
    pd_nxt = pd_r;
    cnt_nxt = cnt_r;
    s_nxt = s_r;
    od_nxt = od_r;
    n_nxt = n_r;
    lim_nxt = lim_r;
    r_nxt = r_r;
    c_nxt = c_r;
    wbase_nxt = wbase_r;
    raddr_nxt = raddr_r;
    i_nxt = i_r;
    j_nxt = j_r;
    k_nxt = k_r;
    sum_nxt = sum_r;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    dcnt_nxt = dcnt_r;
    zero_nxt = zero_r;
    total_nxt = total_r;
    e_nxt = e_r;
    unique case (state_r)
      S_IDLE: begin
        pd_nxt = PDW'((int'(pdim_r) > PIC_DIM_MAX) ? PIC_DIM_MAX : int'(pdim_r));
        cnt_nxt = SW'((int'(ocnt_r) > OBJ_SLOTS) ? OBJ_SLOTS : int'(ocnt_r));
        s_nxt = '0;
        total_nxt = '0;
        e_nxt = '0;
      end
      S_OBJ: begin
        od_nxt = dims_r[SIW'(s_r)];
        n_nxt = NW'(int'(dims_r[SIW'(s_r)]) * int'(dims_r[SIW'(s_r)]));
      end
      S_LIM: begin
        // floor(sum / n) <= thr exactly when sum <= thr * n + n - 1.
        lim_nxt = SUMW'(thr_r) * SUMW'(n_r) + SUMW'(n_r) - 1'b1;
        r_nxt = '0;
        c_nxt = '0;
        wbase_nxt = '0;
        raddr_nxt = '0;
        i_nxt = '0;
        j_nxt = '0;
        k_nxt = '0;
        sum_nxt = '0;
      end
      S_RD: begin
      end
      S_LD: begin
        zero_nxt = (pic_q == '0);
        rem_nxt = '0;
        quo_nxt = {diff, 16'h0000};
        dcnt_nxt = '0;
      end
      S_DIV: begin
        dcnt_nxt = dcnt_r + 1'b1;
        if (!dif[PIXEL_BITS+1]) begin
          rem_nxt = dif[PIXEL_BITS-1:0];
          quo_nxt = {quo_r[QW-2:0], 1'b1};
        end else begin
          rem_nxt = tmp[PIXEL_BITS-1:0];
          quo_nxt = {quo_r[QW-2:0], 1'b0};
        end
      end
      S_ACC: begin
        sum_nxt = sum_r + SUMW'(term);
        k_nxt = k_r + 1'b1;
        if (j_r == od_r - 1'b1) begin
          j_nxt = '0;
          i_nxt = i_r + 1'b1;
          raddr_nxt = PAW'(int'(raddr_r) + int'(pd_r) + 1 - int'(od_r));
        end else begin
          j_nxt = j_r + 1'b1;
          raddr_nxt = raddr_r + 1'b1;
        end
      end
      S_CMP: begin
        i_nxt = '0;
        j_nxt = '0;
        k_nxt = '0;
        sum_nxt = '0;
        if (sum_r <= lim_r) begin
          if (rec) begin
            total_nxt = total_r + 1'b1;
          end
        end else if (int'(c_r) + int'(od_r) < int'(pd_r)) begin
          c_nxt = c_r + 1'b1;
          wbase_nxt = wbase_r + 1'b1;
          raddr_nxt = wbase_r + 1'b1;
        end else if (int'(r_r) + int'(od_r) < int'(pd_r)) begin
          // From the last column, the next row starts od pixels further on.
          r_nxt = r_r + 1'b1;
          c_nxt = '0;
          wbase_nxt = wbase_r + PAW'(od_r);
          raddr_nxt = wbase_r + PAW'(od_r);
        end
      end
      S_NEXT: s_nxt = s_r + 1'b1;
      S_EMIT: if (out_free && (e_r != total_r)) e_nxt = e_r + 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pdim_r <= 7'd64;
      ocnt_r <= '0;
      thr_r <= '0;
      total_r <= '0;
      out_valid_r <= 1'b0;
      for (int q = 0; q < OBJ_SLOTS; q++) begin
        ids_r[q] <= '0;
        dims_r[q] <= ODW'(1);
      end
      for (int q = 0; q < FOUND_NEEDED; q++) begin
        fids_r[q] <= '0;
        frow_r[q] <= '0;
        fcol_r[q] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      total_r <= total_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_PICTURE_DIM: pdim_r <= cfg_data[6:0];
          CFG_OBJECT_COUNT: ocnt_r <= cfg_data[3:0];
          CFG_MATCH_THRESHOLD: thr_r <= cfg_data;
          default: begin
          end
        endcase
      end
      if (in_acc && (in_data.operation == OP_OBJ_HEADER) && (int'(in_data.slot) < OBJ_SLOTS))
      begin
        ids_r[SIW'(in_data.slot)] <= in_data.header_id;
        dims_r[SIW'(in_data.slot)] <= hdim_sat;
      end
      if ((state_r == S_CMP) && (sum_r <= lim_r) && rec) begin
        fids_r[FIW'(total_r)] <= cur_id;
        frow_r[FIW'(total_r)] <= r_r;
        fcol_r[FIW'(total_r)] <= c_r;
      end
      if (state_r == S_EMIT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pd_r <= pd_nxt;
    cnt_r <= cnt_nxt;
    s_r <= s_nxt;
    od_r <= od_nxt;
    n_r <= n_nxt;
    lim_r <= lim_nxt;
    r_r <= r_nxt;
    c_r <= c_nxt;
    wbase_r <= wbase_nxt;
    raddr_r <= raddr_nxt;
    i_r <= i_nxt;
    j_r <= j_nxt;
    k_r <= k_nxt;
    sum_r <= sum_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dcnt_r <= dcnt_nxt;
    zero_r <= zero_nxt;
    e_r <= e_nxt;
    if (state_r == S_EMIT && out_free) begin
      if (e_r == total_r) begin
        out_data_r.kind <= KIND_STATUS;
        out_data_r.found_id <= '0;
        out_data_r.found_row <= '0;
        out_data_r.found_col <= '0;
        out_data_r.found_count <= 2'(total_r);
        out_data_r.three_found <= (int'(total_r) >= FOUND_NEEDED) && distinct;
        out_data_r.last <= 1'b1;
      end else begin
        out_data_r.kind <= KIND_FOUND;
        out_data_r.found_id <= fids_r[FIW'(e_r)];
        out_data_r.found_row <= 6'(frow_r[FIW'(e_r)]);
        out_data_r.found_col <= 6'(fcol_r[FIW'(e_r)]);
        out_data_r.found_count <= 2'(e_r + 1'b1);
        out_data_r.three_found <= 1'b0;
        out_data_r.last <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;
  assign cfg_ready = 1'b1;

endmodule

// ----- rtl/core/trds_checker.sv -----
`timescale 1ns / 1ps
module trds_checker
  import trds_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_word_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_word_t out_data
);

  // A word held by a stalled receiver must not drop.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("output word dropped while stalled");

  // An accepted run keeps the input side busy on the next cycle.
  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.operation == OP_RUN) |=> in_stall)
    else $error("input accepted right after a run word");

  // The final word of a run is always a status word.
  a_last_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last |-> out_data.kind == KIND_STATUS)
    else $error("last flag on a found entry");

  // Found entries never carry the status flags and count at least one.
  a_found_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.kind == KIND_FOUND) |->
      !out_data.last && !out_data.three_found && (out_data.found_count != 2'd0))
    else $error("malformed found entry");

endmodule

bind template_relative_diff_search trds_checker u_trds_checker (.*);
